FILE: hdl/lruwb_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lruwb_pkg
// Shared types and constants of the LRU write buffer tag manager.
// ----------------------------------------------------------------------------
package lruwb_pkg;

	// Access codes carried by the operation field
	typedef enum logic [1:0] {
		OP_WRITE = 2'd0,
		OP_PROBE = 2'd1,
		OP_TOUCH = 2'd2
	} op_t;

	// Register word select (paddr[2]) of the capacity register
	localparam logic REG_CAPACITY_SEL = 1'b0;

	// Capacity after reset
	localparam logic [4:0] CAP_RESET = 5'd16;

	// Search flags passed from the lookup to the update logic
	typedef struct packed {
		logic hit;
		logic victim_found;
		logic slot_found;
	} lookup_t;

endpackage : lruwb_pkg
`default_nettype wire

FILE: hdl/lruwb_lookup.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lruwb_lookup
// Parallel tag match, least recent line search and free slot search.
// ----------------------------------------------------------------------------
module lruwb_lookup import lruwb_pkg::*; #(
	parameter int MAX_LINES = 16,
	parameter int TAG_W     = 32,
	parameter int IDX_W     = 4,
	parameter int CNT_W     = 5
) (
	input  wire logic [TAG_W-1:0] tag [MAX_LINES],
	input  wire logic [MAX_LINES-1:0] line_valid,
	input  wire logic [IDX_W-1:0] age [MAX_LINES],
	input  wire logic [CNT_W-1:0] valid_count,
	input  wire logic [TAG_W-1:0] page,
	input  wire logic             evict_req,
	output lookup_t               flags,
	output logic [IDX_W-1:0]      hit_idx,
	output logic [IDX_W-1:0]      victim_idx,
	output logic [IDX_W-1:0]      slot_idx
);

	logic [CNT_W-1:0]     oldest_age;
	logic [MAX_LINES-1:0] victim_vec;
	logic [MAX_LINES-1:0] free_vec;
	logic                 hit_found;
	logic                 victim_found;
	logic                 slot_found;

	assign oldest_age = valid_count - CNT_W'(1);

	// Match tags and locate the line holding the oldest age
	always_comb begin
		hit_found    = 1'b0;
		victim_found = 1'b0;
		hit_idx      = '0;
		victim_idx   = '0;
		victim_vec   = '0;
		for (int i = 0; i < MAX_LINES; i++) begin
			if (line_valid[i] && tag[i] == page) begin
				hit_found = 1'b1;
				hit_idx   = IDX_W'(i);
			end
			if (line_valid[i] && CNT_W'(age[i]) == oldest_age) begin
				victim_found  = 1'b1;
				victim_idx    = IDX_W'(i);
				victim_vec[i] = 1'b1;
			end
		end
	end

	// Pick the lowest free line, counting the victim as free on eviction
	always_comb begin
		free_vec   = ~line_valid;
		slot_found = 1'b0;
		slot_idx   = '0;
		if (evict_req) begin
			free_vec = free_vec | victim_vec;
		end
		for (int i = MAX_LINES - 1; i >= 0; i--) begin
			if (free_vec[i]) begin
				slot_found = 1'b1;
				slot_idx   = IDX_W'(i);
			end
		end
	end

	// Gather the search flags
	assign flags = '{hit: hit_found, victim_found: victim_found, slot_found: slot_found};

endmodule : lruwb_lookup
`default_nettype wire

FILE: hdl/lru_write_buffer_tag_manager_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lru_write_buffer_tag_manager_unit
// Tag and LRU recency manager of a fully associative write-back page buffer.
//
// Requests enter on the req channel (operation, page_number, full_page) and
// are transferred when req_valid is high and req_stall is low. Each request
// gives one result on the rsp channel, transferred when rsp_valid is high and
// rsp_stall is low. A request sits in an input register, where the tag
// compare, victim search and age update are done in one pass against the
// line state; once the result slot is free, the result lands in an output
// register. One request is taken every cycle while rsp_stall is low.
// The state update of one request is in place before the next one is looked
// at, so back-to-back requests to the same page need no bypass.
// While the receiver stalls, the result holds, the input register keeps its
// request and req_stall rises once that register is full.
// Reset empties the buffer: all lines invalid and clean, counters zero,
// capacity 16. Capacity is written over the APB port at address 0; the
// user must write it only while the block is idle, which is not enforced.
// ----------------------------------------------------------------------------
module lru_write_buffer_tag_manager_unit import lruwb_pkg::*; #(
	parameter int MAX_LINES = 16,
	parameter int PAGE_BITS = 32
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// configuration port
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready,
	// request channel
	input  wire logic        req_valid,
	output logic             req_stall,
	input  wire logic [1:0]  operation,
	input  wire logic [31:0] page_number,
	input  wire logic        full_page,
	// response channel
	output logic             rsp_valid,
	input  wire logic        rsp_stall,
	output logic             hit,
	output logic             evicted,
	output logic      [31:0] victim_page,
	output logic             victim_dirty,
	output logic             fetch_needed,
	output logic      [4:0]  occupancy,
	output logic      [4:0]  dirty_cnt,
	output logic      [31:0] evict_cnt
);

	localparam int TAG_W = (PAGE_BITS < 32) ? PAGE_BITS : 32;
	localparam int IDX_W = (MAX_LINES > 1) ? $clog2(MAX_LINES) : 1;
	localparam int CNT_W = $clog2(MAX_LINES + 1);
	localparam int CMP_W = (CNT_W > 5) ? CNT_W : 5;

	// line state
	logic [TAG_W-1:0]     tag_q [MAX_LINES];
	logic [MAX_LINES-1:0] valid_q;
	logic [MAX_LINES-1:0] dirty_q;
	logic [IDX_W-1:0]     age_q [MAX_LINES];
	logic [CNT_W-1:0]     vcount_q;
	logic [CNT_W-1:0]     dcount_q;
	logic [31:0]          evict_cnt_q;
	logic [4:0]           cap_q;

	// input stage
	logic                 valid_s1;
	logic [1:0]           op_s1;
	logic [TAG_W-1:0]     page_s1;
	logic                 full_s1;

	// result stage
	logic                 valid_s2;
	logic                 hit_s2;
	logic                 evicted_s2;
	logic [31:0]          vpage_s2;
	logic                 vdirty_s2;
	logic                 fetch_s2;
	logic [4:0]           occ_s2;
	logic [4:0]           dirty_s2;

	// next state and lookup results
	logic [MAX_LINES-1:0] valid_n;
	logic [MAX_LINES-1:0] dirty_n;
	logic [IDX_W-1:0]     age_n [MAX_LINES];
	logic [CNT_W-1:0]     vcount_n;
	logic [CNT_W-1:0]     dcount_n;
	logic [31:0]          evict_cnt_n;
	lookup_t              flags;
	logic [IDX_W-1:0]     hit_idx;
	logic [IDX_W-1:0]     victim_idx;
	logic [IDX_W-1:0]     slot_idx;
	logic [IDX_W-1:0]     hit_age;
	logic [CMP_W-1:0]     cap_w;
	logic [CMP_W-1:0]     cap_eff;
	logic                 is_write;
	logic                 is_touch;
	logic                 evict_req;
	logic                 do_evict;
	logic                 do_insert;
	logic                 do_recent;
	logic                 vdirty;
	logic [TAG_W+31:0]    vpage_ext;
	logic [CNT_W+4:0]     occ_ext;
	logic [CNT_W+4:0]     dirty_ext;
	logic                 adv_s1;
	logic                 take;
	logic                 cfg_wr;

	// Handshake: the input register moves on when the result slot is free
	assign adv_s1    = valid_s1 && (!valid_s2 || !rsp_stall);
	assign req_stall = valid_s1 && !adv_s1;
	assign take      = req_valid && !req_stall;

	// Configuration port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;
	assign prdata = (paddr[2] == REG_CAPACITY_SEL) ? {27'b0, cap_q} : 32'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
		end else if (cfg_wr && paddr[2] == REG_CAPACITY_SEL) begin
			cap_q <= pwdata[4:0];
		end
	end

	// Clamp capacity to one through MAX_LINES
	always_comb begin
		cap_w   = CMP_W'(cap_q);
		cap_eff = cap_w;
		if (cap_w == '0) begin
			cap_eff = CMP_W'(1);
		end else if (cap_w > CMP_W'(MAX_LINES)) begin
			cap_eff = CMP_W'(MAX_LINES);
		end
	end

	assign is_write  = (op_s1 == OP_WRITE);
	assign is_touch  = (op_s1 == OP_TOUCH);
	assign evict_req = is_write && (CMP_W'(vcount_q) >= cap_eff);

	lruwb_lookup #(
		.MAX_LINES (MAX_LINES),
		.TAG_W     (TAG_W),
		.IDX_W     (IDX_W),
		.CNT_W     (CNT_W)
	) u_lookup (
		.tag         (tag_q),
		.line_valid  (valid_q),
		.age         (age_q),
		.valid_count (vcount_q),
		.page        (page_s1),
		.evict_req   (evict_req),
		.flags       (flags),
		.hit_idx     (hit_idx),
		.victim_idx  (victim_idx),
		.slot_idx    (slot_idx)
	);

	assign do_evict  = evict_req && !flags.hit && flags.victim_found;
	assign do_insert = is_write && !flags.hit && flags.slot_found;
	assign do_recent = flags.hit && (is_write || is_touch);
	assign hit_age   = age_q[hit_idx];
	assign vdirty    = do_evict && dirty_q[victim_idx];
	assign vpage_ext = do_evict ? {32'b0, tag_q[victim_idx]} : '0;

	// Update each line: recency move, eviction, then insertion
	always_comb begin
		for (int i = 0; i < MAX_LINES; i++) begin
			valid_n[i] = valid_q[i];
			dirty_n[i] = dirty_q[i];
			age_n[i]   = age_q[i];
			if (do_recent) begin
				if (valid_q[i] && age_q[i] < hit_age) begin
					age_n[i] = age_q[i] + IDX_W'(1);
				end
				if (IDX_W'(i) == hit_idx) begin
					age_n[i] = '0;
					if (is_write) begin
						dirty_n[i] = 1'b1;
					end
				end
			end
			if (do_evict && IDX_W'(i) == victim_idx) begin
				valid_n[i] = 1'b0;
				dirty_n[i] = 1'b0;
				age_n[i]   = '0;
			end
			if (do_insert) begin
				if (IDX_W'(i) == slot_idx) begin
					valid_n[i] = 1'b1;
					dirty_n[i] = 1'b1;
					age_n[i]   = '0;
				end else if (valid_n[i]) begin
					age_n[i] = age_q[i] + IDX_W'(1);
				end
			end
		end
	end

	// Update the line and eviction counters
	always_comb begin
		vcount_n    = vcount_q;
		dcount_n    = dcount_q;
		evict_cnt_n = evict_cnt_q;
		if (do_recent && is_write && !dirty_q[hit_idx]) begin
			dcount_n = dcount_n + CNT_W'(1);
		end
		if (do_evict) begin
			vcount_n    = vcount_n - CNT_W'(1);
			evict_cnt_n = evict_cnt_q + 32'd1;
			if (vdirty && dcount_q != '0) begin
				dcount_n = dcount_n - CNT_W'(1);
			end
		end
		if (do_insert) begin
			vcount_n = vcount_n + CNT_W'(1);
			dcount_n = dcount_n + CNT_W'(1);
		end
	end

	assign occ_ext   = {5'b0, vcount_n};
	assign dirty_ext = {5'b0, dcount_n};

	// Capture a request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			op_s1   <= operation;
			page_s1 <= page_number[TAG_W-1:0];
			full_s1 <= full_page;
		end
	end

	// Commit line state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q     <= '0;
			dirty_q     <= '0;
			vcount_q    <= '0;
			dcount_q    <= '0;
			evict_cnt_q <= '0;
			for (int i = 0; i < MAX_LINES; i++) begin
				age_q[i] <= '0;
			end
		end else if (adv_s1) begin
			valid_q     <= valid_n;
			dirty_q     <= dirty_n;
			vcount_q    <= vcount_n;
			dcount_q    <= dcount_n;
			evict_cnt_q <= evict_cnt_n;
			for (int i = 0; i < MAX_LINES; i++) begin
				age_q[i] <= age_n[i];
			end
		end
	end

	// Write the tag of an inserted line
	always_ff @(posedge clk) begin
		if (adv_s1 && do_insert) begin
			tag_q[slot_idx] <= page_s1;
		end
	end

	// Register the result; hold it while stalled
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s1) begin
			valid_s2 <= 1'b1;
		end else if (!rsp_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			hit_s2     <= flags.hit;
			evicted_s2 <= do_evict;
			vpage_s2   <= vpage_ext[31:0];
			vdirty_s2  <= vdirty;
			fetch_s2   <= is_write && !flags.hit && !full_s1;
			occ_s2     <= occ_ext[4:0];
			dirty_s2   <= dirty_ext[4:0];
		end
	end

	assign rsp_valid    = valid_s2;
	assign hit          = hit_s2;
	assign evicted      = evicted_s2;
	assign victim_page  = vpage_s2;
	assign victim_dirty = vdirty_s2;
	assign fetch_needed = fetch_s2;
	assign occupancy    = occ_s2;
	assign dirty_cnt    = dirty_s2;
	assign evict_cnt    = evict_cnt_q;

endmodule : lru_write_buffer_tag_manager_unit
`default_nettype wire
